@@ src/itr_pkg.sv @@
// itr_pkg: shared types, constants and step tables for the integer to roman numeral block
// no dependencies; used by itr_front, itr_queue, itr_back and integer_to_roman_numeral
package itr_pkg;

  localparam int unsigned IN_WIDTH    = 13;
  localparam int unsigned VALUE_WIDTH = 12;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned STEP_COUNT  = 13;
  localparam int unsigned STEP_WIDTH  = 4;
  localparam int unsigned QUEUE_DEPTH = 4;   // power of two

  localparam logic [VALUE_WIDTH-1:0] MAX_VALUE = 12'd3999;

  localparam logic [CHAR_WIDTH-1:0] CHAR_NONE = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CHAR_M    = 8'h4D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_D    = 8'h44;
  localparam logic [CHAR_WIDTH-1:0] CHAR_C    = 8'h43;
  localparam logic [CHAR_WIDTH-1:0] CHAR_L    = 8'h4C;
  localparam logic [CHAR_WIDTH-1:0] CHAR_X    = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CHAR_V    = 8'h56;
  localparam logic [CHAR_WIDTH-1:0] CHAR_I    = 8'h49;

  // what the front part decided about an input transaction
  typedef enum logic [1:0] {
    KIND_ERROR,
    KIND_ZERO,
    KIND_NUMBER
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [VALUE_WIDTH-1:0] value;
  } item_t;

  function automatic logic [VALUE_WIDTH-1:0] step_value(input logic [STEP_WIDTH-1:0] idx);
    logic [VALUE_WIDTH-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] step_first(input logic [STEP_WIDTH-1:0] idx);
    logic [CHAR_WIDTH-1:0] c;
    case (idx)
      4'd0:    c = CHAR_M;
      4'd1:    c = CHAR_C;
      4'd2:    c = CHAR_D;
      4'd3:    c = CHAR_C;
      4'd4:    c = CHAR_C;
      4'd5:    c = CHAR_X;
      4'd6:    c = CHAR_L;
      4'd7:    c = CHAR_X;
      4'd8:    c = CHAR_X;
      4'd9:    c = CHAR_I;
      4'd10:   c = CHAR_V;
      default: c = CHAR_I;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] step_second(input logic [STEP_WIDTH-1:0] idx);
    logic [CHAR_WIDTH-1:0] c;
    case (idx)
      4'd1:    c = CHAR_M;
      4'd3:    c = CHAR_D;
      4'd5:    c = CHAR_C;
      4'd7:    c = CHAR_L;
      4'd9:    c = CHAR_X;
      4'd11:   c = CHAR_V;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

  // largest step value that fits; independent compares, lowest index wins
  function automatic logic [STEP_WIDTH-1:0] pick_step(input logic [VALUE_WIDTH-1:0] rem);
    logic [STEP_WIDTH-1:0] idx;
    idx = STEP_WIDTH'(STEP_COUNT - 1);
    for (int i = STEP_COUNT - 1; i >= 0; i--) begin
      if (rem >= step_value(STEP_WIDTH'(i))) begin
        idx = STEP_WIDTH'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ src/itr_front.sv @@
// itr_front: input side, classifies each transaction as error, zero or number
// depends on itr_pkg
module itr_front (
  input  logic                           in_valid,
  input  logic [itr_pkg::IN_WIDTH-1:0]   in_number,
  input  logic                           queue_full,
  output logic                           in_ready,
  output logic                           push,
  output itr_pkg::item_t                 push_item
);

  logic is_negative;
  logic too_large;

  assign in_ready    = !queue_full;
  assign push        = in_valid && in_ready;
  assign is_negative = in_number[itr_pkg::IN_WIDTH-1];
  assign too_large   = in_number[itr_pkg::VALUE_WIDTH-1:0] > itr_pkg::MAX_VALUE;

  always_comb begin
    push_item.value = in_number[itr_pkg::VALUE_WIDTH-1:0];
    if (is_negative || too_large) begin
      push_item.kind = itr_pkg::KIND_ERROR;
    end else if (in_number[itr_pkg::VALUE_WIDTH-1:0] == '0) begin
      push_item.kind = itr_pkg::KIND_ZERO;
    end else begin
      push_item.kind = itr_pkg::KIND_NUMBER;
    end
  end

endmodule

@@ src/itr_queue.sv @@
// itr_queue: short fifo of classified items between front and back
// depends on itr_pkg
module itr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itr_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output itr_pkg::item_t pop_item
);

  localparam int unsigned AW = $clog2(itr_pkg::QUEUE_DEPTH);

  itr_pkg::item_t entries [itr_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full      = count == (AW+1)'(itr_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ src/itr_back.sv @@
// itr_back: greedy subtraction sequencer, one letter per cycle into an output register
// while out_ready allows; depends on itr_pkg
module itr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_not_empty,
  input  itr_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [itr_pkg::CHAR_WIDTH-1:0]   out_code,
  output logic                             out_char_valid,
  output logic                             out_error,
  output logic                             out_last
);

  logic                              busy;
  logic [itr_pkg::VALUE_WIDTH-1:0]   rem;
  logic [itr_pkg::CHAR_WIDTH-1:0]    pend;

  logic                              busy_next;
  logic [itr_pkg::VALUE_WIDTH-1:0]   rem_next;
  logic [itr_pkg::CHAR_WIDTH-1:0]    pend_next;
  logic [itr_pkg::CHAR_WIDTH-1:0]    code_next;
  logic                              char_valid_next;
  logic                              error_next;
  logic                              last_next;

  logic                              load;
  logic [itr_pkg::VALUE_WIDTH-1:0]   src_value;
  logic [itr_pkg::STEP_WIDTH-1:0]    idx;
  logic [itr_pkg::VALUE_WIDTH-1:0]   diff;
  logic [itr_pkg::CHAR_WIDTH-1:0]    second;

  assign load  = (!out_valid || out_ready) && (busy || q_not_empty);
  assign q_pop = load && !busy;

  assign src_value = busy ? rem : q_item.value;
  assign idx       = itr_pkg::pick_step(src_value);
  assign diff      = src_value - itr_pkg::step_value(idx);
  assign second    = itr_pkg::step_second(idx);

  always_comb begin
    busy_next       = busy;
    rem_next        = rem;
    pend_next       = pend;
    code_next       = itr_pkg::CHAR_NONE;
    char_valid_next = 1'b0;
    error_next      = 1'b0;
    last_next       = 1'b1;
    if (busy && pend != itr_pkg::CHAR_NONE) begin
      // second letter of a subtractive pair
      code_next       = pend;
      char_valid_next = 1'b1;
      pend_next       = itr_pkg::CHAR_NONE;
      last_next       = rem == '0;
      busy_next       = rem != '0;
    end else if (busy || q_item.kind == itr_pkg::KIND_NUMBER) begin
      code_next       = itr_pkg::step_first(idx);
      char_valid_next = 1'b1;
      rem_next        = diff;
      pend_next       = second;
      last_next       = diff == '0 && second == itr_pkg::CHAR_NONE;
      busy_next       = !last_next;
    end else begin
      error_next = q_item.kind == itr_pkg::KIND_ERROR;
      busy_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= itr_pkg::CHAR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy      <= busy_next;
        pend      <= pend_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem            <= rem_next;
      out_code       <= code_next;
      out_char_valid <= char_valid_next;
      out_error      <= error_next;
      out_last       <= last_next;
    end
  end

endmodule

@@ src/integer_to_roman_numeral.sv @@
// integer_to_roman_numeral: top level, converts a signed integer into roman numeral letters
// depends on itr_pkg, itr_front, itr_queue, itr_back
//
// usage:
//   s_axis carries one signed 13-bit integer per transaction (tdata[12:0]).
//   m_axis returns the numeral one ascii letter per transaction, most
//   significant letter first, with tlast on the final letter of each run.
//   tuser[0] marks a letter in tdata; zero input gives one transaction with
//   tuser[0] low; a negative input or one above 3999 gives one transaction
//   with tuser[1] (error) set, both ending with tlast.
// timing:
//   the first result passes through the queue and then the output register;
//   an input gives 1 to 15 results, set by the letter count of its numeral
//   (the back sequencer emits one per cycle while m_axis_tready allows).
//   a four-entry queue lets several inputs be accepted while a run is
//   still being emitted; s_axis_tready drops only when the queue is full.
// reset: rst (synchronous, active high) empties the queue, stops any run
//   and clears m_axis_tvalid.
// stall: when m_axis_tready is low the output register holds its
//   transaction and the sequencer waits; input keeps filling the queue.
module integer_to_roman_numeral (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [12:0] number_in, [15:13] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic [1:0]  m_axis_tuser,   // [0] char_valid, [1] error_flag
  output logic        m_axis_tlast    // last_char
);

  // front to queue
  logic           push;
  itr_pkg::item_t push_item;
  logic           queue_full;

  // queue to back
  logic           q_pop;
  logic           q_not_empty;
  itr_pkg::item_t q_item;

  // output register fields
  logic [itr_pkg::CHAR_WIDTH-1:0] char_code;
  logic                           char_valid;
  logic                           error_flag;
  logic                           last_char;

  // classify each input transaction
  itr_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_number  (s_axis_tdata[itr_pkg::IN_WIDTH-1:0]),
    .queue_full (queue_full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_item  (push_item)
  );

  // decouples input acceptance from letter emission
  itr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (queue_full),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  // greedy subtraction, one letter per cycle while m_axis_tready allows it
  itr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_code       (char_code),
    .out_char_valid (char_valid),
    .out_error      (error_flag),
    .out_last       (last_char)
  );

  assign m_axis_tdata = char_code;
  assign m_axis_tuser = {error_flag, char_valid};
  assign m_axis_tlast = last_char;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for integer_to_roman_numeral, a directed table then random values
// depends on itr_pkg (letter codes, MAX_VALUE) and the integer_to_roman_numeral rtl
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is declared hung
  localparam int LONG_HOLD      = 300;   // receiver back-pressure stretch, in cycles
  localparam int RANDOM_ITEMS   = 305;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int STEPS          = 13;
  localparam int DIR_ROWS       = 25;

  // one output transaction as the checker sees it
  typedef struct packed {
    logic [7:0] code;
    logic       letter;
    logic       err;
    logic       last;
  } glyph_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    ROW_ERROR,    // single error transaction
    ROW_ZERO,     // single empty transaction
    ROW_TEXT,     // numeral spelled out in the row
    ROW_PREDICT   // left to the predictor
  } row_kind_t;

  typedef struct {
    int        num;
    row_kind_t kind;
    string     text;
  } row_t;

  // greedy subtraction steps, largest first; a step with a tail letter is a
  // subtractive pair such as CM or IV
  localparam int STEP_AMOUNT [STEPS] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  localparam logic [7:0] STEP_LEAD [STEPS] = '{
    itr_pkg::CHAR_M, itr_pkg::CHAR_C, itr_pkg::CHAR_D, itr_pkg::CHAR_C, itr_pkg::CHAR_C,
    itr_pkg::CHAR_X, itr_pkg::CHAR_L, itr_pkg::CHAR_X, itr_pkg::CHAR_X, itr_pkg::CHAR_I,
    itr_pkg::CHAR_V, itr_pkg::CHAR_I, itr_pkg::CHAR_I};
  localparam logic [7:0] STEP_TAIL [STEPS] = '{
    itr_pkg::CHAR_NONE, itr_pkg::CHAR_M, itr_pkg::CHAR_NONE, itr_pkg::CHAR_D,
    itr_pkg::CHAR_NONE, itr_pkg::CHAR_C, itr_pkg::CHAR_NONE, itr_pkg::CHAR_L,
    itr_pkg::CHAR_NONE, itr_pkg::CHAR_X, itr_pkg::CHAR_NONE, itr_pkg::CHAR_V,
    itr_pkg::CHAR_NONE};

  // directed stimulus: range edges, every subtractive pair and the single letters I, V, L, D, M,
  // the longest numeral, errors on both sides and two zero inputs
  row_t dir_rows [DIR_ROWS] = '{
    '{0,     ROW_ZERO,    ""},
    '{1,     ROW_TEXT,    "I"},
    '{3999,  ROW_TEXT,    "MMMCMXCIX"},
    '{4000,  ROW_ERROR,   ""},
    '{4095,  ROW_ERROR,   ""},
    '{-1,    ROW_ERROR,   ""},
    '{-4096, ROW_ERROR,   ""},
    '{-4000, ROW_ERROR,   ""},
    '{3888,  ROW_TEXT,    "MMMDCCCLXXXVIII"},
    '{4,     ROW_TEXT,    "IV"},
    '{9,     ROW_TEXT,    "IX"},
    '{40,    ROW_TEXT,    "XL"},
    '{90,    ROW_TEXT,    "XC"},
    '{400,   ROW_TEXT,    "CD"},
    '{900,   ROW_TEXT,    "CM"},
    '{5,     ROW_TEXT,    "V"},
    '{50,    ROW_TEXT,    "L"},
    '{500,   ROW_TEXT,    "D"},
    '{1000,  ROW_TEXT,    "M"},
    '{3000,  ROW_TEXT,    "MMM"},
    '{3,     ROW_PREDICT, ""},
    '{1994,  ROW_PREDICT, ""},
    '{2444,  ROW_PREDICT, ""},
    '{0,     ROW_ZERO,    ""},
    '{3998,  ROW_PREDICT, ""}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  glyph_t numeral_q [$];     // letters still owed by the block, oldest first
  int     mismatches = 0;
  bit     tx_idle_on = 1'b1; // sender inserts gaps while set
  bit     rx_idle_on = 1'b1; // receiver inserts stalls while set
  bit     long_hold_req = 1'b0;

  integer_to_roman_numeral DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // queue up the letters one input value should produce
  function automatic void predict_numeral(input logic [12:0] raw);
    int     value;
    int     rest;
    int     k;
    glyph_t run_q [$];
    value = int'($signed(raw));
    if (value < 0 || value > int'(itr_pkg::MAX_VALUE)) begin
      numeral_q.push_back('{code: itr_pkg::CHAR_NONE, letter: 1'b0, err: 1'b1, last: 1'b1});
    end else if (value == 0) begin
      numeral_q.push_back('{code: itr_pkg::CHAR_NONE, letter: 1'b0, err: 1'b0, last: 1'b1});
    end else begin
      rest = value;
      while (rest != 0) begin
        k = 0;
        while (STEP_AMOUNT[k] > rest) k++;
        run_q.push_back('{code: STEP_LEAD[k], letter: 1'b1, err: 1'b0, last: 1'b0});
        if (STEP_TAIL[k] != itr_pkg::CHAR_NONE) begin
          run_q.push_back('{code: STEP_TAIL[k], letter: 1'b1, err: 1'b0, last: 1'b0});
        end
        rest -= STEP_AMOUNT[k];
      end
      run_q[run_q.size() - 1].last = 1'b1;
      foreach (run_q[i]) numeral_q.push_back(run_q[i]);
    end
  endfunction

  // expectation for a directed row: typed in where obvious, predicted otherwise
  function automatic void expect_row(input row_t row);
    int len;
    len = row.text.len();
    case (row.kind)
      ROW_ERROR: begin
        numeral_q.push_back('{code: itr_pkg::CHAR_NONE, letter: 1'b0, err: 1'b1, last: 1'b1});
      end
      ROW_ZERO: begin
        numeral_q.push_back('{code: itr_pkg::CHAR_NONE, letter: 1'b0, err: 1'b0, last: 1'b1});
      end
      ROW_TEXT: begin
        for (int i = 0; i < len; i++) begin
          numeral_q.push_back('{code: 8'(row.text[i]), letter: 1'b1, err: 1'b0,
                                last: (i == len - 1)});
        end
      end
      default: begin
        predict_numeral(13'(row.num));
      end
    endcase
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    else if (r < 92) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // random input value; weighted toward convertible numbers, with long numerals,
  // zeros, negatives, values above the maximum and raw 13-bit patterns mixed in
  function automatic logic [12:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 13'($urandom_range(1, 3999));
    else if (r < 52) return 13'($urandom_range(1, 99));
    else if (r < 68) return 13'($urandom_range(3000, 3999));
    else if (r < 75) return 13'd0;
    else if (r < 86) return 13'($urandom_range(4096, 8191));  // negative patterns
    else if (r < 94) return 13'($urandom_range(4000, 4095));
    else return 13'($urandom);
  endfunction

  // offer one value on the input side and wait for its transaction; valid stays
  // high across back-to-back values so only one assignment lands per edge
  task automatic offer(input logic [12:0] raw);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 35) ? pick_pause() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, raw};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // sender: reset, directed table, random values, then drain and verdict
  initial begin : source
    int          hold_at;
    logic [12:0] raw;
    hold_at = $urandom_range(40, 120);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer(13'(dir_rows[i].num));
      expect_row(dir_rows[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 39) == 0) tx_idle_on = !tx_idle_on;
      // receiver backs off for a long stretch while we keep pushing values
      if (i == hold_at) long_hold_req = 1'b1;
      raw = pick_number();
      offer(raw);
      predict_numeral(raw);
    end
    s_axis_tvalid <= 1'b0;
    while (numeral_q.size() != 0) @(posedge clk);
    // give a stray extra letter time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && numeral_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 59) == 0) rx_idle_on = !rx_idle_on;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 99) < 25) stall_left = pick_pause();
      end
    end
  end

  // compare each output transaction against the oldest owed letter
  always @(posedge clk) begin : check_letters
    glyph_t got;
    glyph_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{code: m_axis_tdata, letter: m_axis_tuser[0], err: m_axis_tuser[1],
              last: m_axis_tlast};
      if (numeral_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected transaction code %h letter %b err %b last %b",
                   $time, got.code, got.letter, got.err, got.last);
        end
      end else begin
        want = numeral_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch exp code %h letter %b err %b last %b", $time,
                     want.code, want.letter, want.err, want.last);
            $display("%0t:          got code %h letter %b err %b last %b", $time,
                     got.code, got.letter, got.err, got.last);
          end
        end
      end
    end
  end

  // watchdog: too many cycles with no transaction on either side means a hang
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog timeout, %0d letters still owed", numeral_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/itr_pkg.sv
src/itr_front.sv
src/itr_queue.sv
src/itr_back.sv
src/integer_to_roman_numeral.sv
tb/sv/tb_top.sv
